FILE: sv/mts_pkg.sv
package mts_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // capture input word
    logic exec;       // apply push/pop to pointers and stores
    logic load_tops;  // load top caches from registered store reads
    logic load_out;   // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;  // pending op is a pop on a non-empty stack
    logic out_free;   // result register can take a new word
  } sts_t;

endpackage

FILE: sv/mts_ctrl.sv
module mts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mts_pkg::sts_t sts,
  output mts_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_read ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        cmd.load_tops = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_EXEC)
    else $error("accept did not start execution");

  a_read_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> $past(state_r) == ST_EXEC && $past(sts.need_read))
    else $error("store read without a pop");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.exec, cmd.load_tops, cmd.load_out}))
    else $error("overlapping commands");

endmodule

FILE: sv/mts_dp.sv
module mts_dp #(
  parameter int DEPTH      = mts_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF,
  localparam int IW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mts_pkg::cmd_t                cmd,
  output mts_pkg::sts_t                sts,
  input  logic                         in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_top_value,
  output logic signed [DATA_WIDTH-1:0] out_min_value,
  output logic        [CW-1:0]         out_entry_count,
  output logic                         out_is_empty,
  output logic        [1:0]            out_status
);

  logic signed [DATA_WIDTH-1:0] vmem [DEPTH];
  logic signed [DATA_WIDTH-1:0] mmem [DEPTH];

  logic                         op_r;
  logic signed [DATA_WIDTH-1:0] val_r;
  logic        [CW-1:0]         vp_r, vp_nxt, mp_r, mp_nxt;
  logic signed [DATA_WIDTH-1:0] top_r, mtop_r, vrd_r, mrd_r;
  mts_pkg::status_t             status_r, status_nxt;

  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_top_r, out_min_r;
  logic        [CW-1:0]         out_count_r;
  logic                         out_empty_r;
  mts_pkg::status_t             out_status_r;

  logic          full, empty, push_ok, min_push, pop_ok, min_pop;
  logic [IW-1:0] vrd_idx, mrd_idx;

  always_comb begin
    full     = vp_r == CW'(DEPTH);
    empty    = vp_r == '0;
    push_ok  = (op_r == mts_pkg::MODE_PUSH) && !full;
    min_push = push_ok && (mp_r < CW'(DEPTH)) && ((mp_r == '0) || (val_r <= mtop_r));
    pop_ok   = (op_r == mts_pkg::MODE_POP) && !empty;
    min_pop  = pop_ok && (mp_r != '0) && (mtop_r == top_r);

    vp_nxt     = vp_r;
    mp_nxt     = mp_r;
    status_nxt = mts_pkg::STATUS_OK;
    if (op_r == mts_pkg::MODE_PUSH) begin
      if (full) status_nxt = mts_pkg::STATUS_FULL;
    end else begin
      if (empty) status_nxt = mts_pkg::STATUS_EMPTY;
    end
    if (push_ok) vp_nxt = vp_r + CW'(1);
    if (pop_ok) vp_nxt = vp_r - CW'(1);
    if (min_push) mp_nxt = mp_r + CW'(1);
    if (min_pop) mp_nxt = mp_r - CW'(1);

    // new tops sit one below the updated pointers
    vrd_idx = IW'(vp_nxt - CW'(1));
    mrd_idx = IW'(mp_nxt - CW'(1));
  end

  assign sts.need_read = pop_ok;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (push_ok) vmem[vp_r[IW-1:0]] <= val_r;
      if (min_push) mmem[mp_r[IW-1:0]] <= val_r;
      vrd_r <= vmem[vrd_idx];
      mrd_r <= mmem[mrd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_mode;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      if (push_ok) top_r <= val_r;
      if (min_push) mtop_r <= val_r;
    end
    if (cmd.load_tops) begin
      top_r  <= vrd_r;
      mtop_r <= mrd_r;
    end
    if (cmd.load_out) begin
      out_top_r    <= (vp_r != '0) ? top_r : '0;
      out_min_r    <= (mp_r != '0) ? mtop_r : '0;
      out_count_r  <= vp_r;
      out_empty_r  <= vp_r == '0;
      out_status_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r        <= '0;
      mp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        vp_r <= vp_nxt;
        mp_r <= mp_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_min_value   = out_min_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_status      = out_status_r;

  a_min_not_above_count: assert property (@(posedge clk) disable iff (!rst_n)
    mp_r <= vp_r)
    else $error("minimum stack deeper than value stack");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vp_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_push_sets_top: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && push_ok |=> top_r == $past(val_r) && vp_r == $past(vp_r) + CW'(1))
    else $error("push did not update top");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && status_r == mts_pkg::STATUS_FULL |-> vp_r == CW'(DEPTH))
    else $error("full status with free room");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result overwritten before taken");

endmodule

FILE: sv/min_tracking_stack_top.sv
// Channel  Handshake             Fields, port prefix in_ / out_
// in       in_valid, in_ready    mode, value
// out      out_valid, out_ready  top_value, min_value, entry_count, is_empty, status
//
// A push or a failed pop goes through accept, execute and result load; the next
// word is taken once the result is loaded. A pop that removes an entry adds a
// step for the registered read of the new tops from the value and minimum stores.
// rst_n is synchronous; both stacks come up empty, no clearing pass.
// The next word is accepted while a result waits in the output register;
// a stalled out_ready holds execution in the final step only.
module min_tracking_stack_top #(
  parameter int DEPTH      = mts_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_top_value,
  output logic signed [DATA_WIDTH-1:0] out_min_value,
  output logic        [CW-1:0]         out_entry_count,
  output logic                         out_is_empty,
  output logic        [1:0]            out_status
);

  mts_pkg::cmd_t cmd;
  mts_pkg::sts_t sts;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mts_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_top_value   (out_top_value),
    .out_min_value   (out_min_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

endmodule
